>>> hdl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col patch scatter - shared definitions
// Field widths, register codes, beat and command types, step reciprocals.
// ----------------------------------------------------------------------------
package im2col_pkg;

   localparam int MAX_IMAGE_DIM  = 256;
   localparam int MAX_KERNEL_DIM = 8;
   localparam int MAX_CHANNELS   = 64;
   localparam int MAX_BATCH      = 256;
   localparam int MAX_STEP       = 8;

   // register widths
   localparam int CH_W   = 7;
   localparam int DIM_W  = 9;
   localparam int KER_W  = 4;
   localparam int STEP_W = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP        = 3'd5;

   localparam logic [CH_W-1:0]   CHANNELS_RST    = 7'd1;
   localparam logic [DIM_W-1:0]  IMAGE_ROWS_RST  = 9'd8;
   localparam logic [DIM_W-1:0]  IMAGE_COLS_RST  = 9'd8;
   localparam logic [KER_W-1:0]  KERNEL_ROWS_RST = 4'd3;
   localparam logic [KER_W-1:0]  KERNEL_COLS_RST = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RST        = 4'd1;

   // field widths
   localparam int COORD_W = 8;
   localparam int CHAN_W  = 6;
   localparam int WORD_W  = 32;
   localparam int ROW_W   = 24;
   localparam int COL_W   = 12;

   // internal widths
   localparam int RECIP_W  = 12;
   localparam int RECIP_SH = 11;
   localparam int KOFF_W   = 3;   // kernel offset and span count, below MAX_KERNEL_DIM
   localparam int PCNT_W   = 17;  // patch count up to MAX_IMAGE_DIM squared
   localparam int AREA_W   = 7;   // kernel area up to MAX_KERNEL_DIM squared

   // command queue between front and back
   localparam int Q_DEPTH = 8;
   localparam int QPTR_W  = 3;
   localparam int QCNT_W  = 4;

   // derived-register values for the reset configuration
   localparam int MR_RST     = 8 - 3;
   localparam int PROW_RST   = MR_RST / 1 + 1;
   localparam int PCOUNT_RST = PROW_RST * PROW_RST;

   typedef struct packed {
      logic [COORD_W-1:0]       batch_index;
      logic [COORD_W-1:0]       pixel_row;
      logic [COORD_W-1:0]       pixel_col;
      logic [CHAN_W-1:0]        channel_index;
      logic signed [WORD_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]         matrix_row;
      logic [COL_W-1:0]         matrix_col;
      logic signed [WORD_W-1:0] sample_res;
      logic                     last;
   } rsp_type;

   // clamped registers and values derived from them
   typedef struct packed {
      logic [CH_W-1:0]    ch;
      logic [DIM_W-1:0]   ir;
      logic [DIM_W-1:0]   ic;
      logic [KER_W-1:0]   kr;
      logic [KER_W-1:0]   kc;
      logic [STEP_W-1:0]  st;
      logic [RECIP_W-1:0] recip;
      logic [COORD_W-1:0] mr;      // last valid patch top
      logic [COORD_W-1:0] mc;      // last valid patch left
      logic               geom_ok;
      logic [DIM_W-1:0]   pcol;
      logic [PCNT_W-1:0]  pcount;
      logic [AREA_W-1:0]  ka;
      logic [AREA_W-1:0]  stkc;    // step times kernel width
   } cfg_type;

   // one queued item: first placement and span of the walk
   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [WORD_W-1:0] sample;
      logic [KOFF_W-1:0]        nr;
      logic [KOFF_W-1:0]        nc;
   } cmd_type;

   // ceil(2^RECIP_SH / step), exact floor for dividends below 263
   function automatic logic [RECIP_W-1:0] step_recip(input logic [STEP_W-1:0] st);
      logic [RECIP_W-1:0] r;
      case (st)
         4'd1:    r = 12'd2048;
         4'd2:    r = 12'd1024;
         4'd3:    r = 12'd683;
         4'd4:    r = 12'd512;
         4'd5:    r = 12'd410;
         4'd6:    r = 12'd342;
         4'd7:    r = 12'd293;
         4'd8:    r = 12'd256;
         default: r = 12'd2048;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/im2col_csr.sv
// ----------------------------------------------------------------------------
// im2col configuration registers
// Holds the six registers, clamps them and keeps the derived geometry.
// ----------------------------------------------------------------------------
module im2col_csr import im2col_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [CH_W-1:0]   channels_ff, channels_in;
   logic [DIM_W-1:0]  image_rows_ff, image_rows_in;
   logic [DIM_W-1:0]  image_cols_ff, image_cols_in;
   logic [KER_W-1:0]  kernel_rows_ff, kernel_rows_in;
   logic [KER_W-1:0]  kernel_cols_ff, kernel_cols_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CH_W-1:0]    ch_c;
   logic [DIM_W-1:0]   ir_c, ic_c;
   logic [KER_W-1:0]   kr_c, kc_c;
   logic [STEP_W-1:0]  st_c;
   logic [RECIP_W-1:0] recip_c;
   logic [DIM_W-1:0]   mr_full, mc_full;
   logic [19:0]        prow_prod, pcol_prod;
   logic [7:0]         ka_full, stkc_full;
   logic [17:0]        pcount_full;

   // first derived level
   logic [COORD_W-1:0] mr_ff, mc_ff;
   logic               geom_ok_ff;
   logic [DIM_W-1:0]   prow_ff, pcol_ff;
   logic [AREA_W-1:0]  ka_ff, stkc_ff;
   logic [RECIP_W-1:0] recip_ff;
   // second derived level
   logic [PCNT_W-1:0]  pcount_ff;

   always_comb begin
      channels_in    = channels_ff;
      image_rows_in  = image_rows_ff;
      image_cols_in  = image_cols_ff;
      kernel_rows_in = kernel_rows_ff;
      kernel_cols_in = kernel_cols_ff;
      step_in        = step_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNELS:    channels_in    = csr_wdata[CH_W-1:0];
            CSR_IMAGE_ROWS:  image_rows_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_COLS:  image_cols_in  = csr_wdata[DIM_W-1:0];
            CSR_KERNEL_ROWS: kernel_rows_in = csr_wdata[KER_W-1:0];
            CSR_KERNEL_COLS: kernel_cols_in = csr_wdata[KER_W-1:0];
            CSR_STEP:        step_in        = csr_wdata[STEP_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff    <= CHANNELS_RST;
         image_rows_ff  <= IMAGE_ROWS_RST;
         image_cols_ff  <= IMAGE_COLS_RST;
         kernel_rows_ff <= KERNEL_ROWS_RST;
         kernel_cols_ff <= KERNEL_COLS_RST;
         step_ff        <= STEP_RST;
      end else begin
         channels_ff    <= channels_in;
         image_rows_ff  <= image_rows_in;
         image_cols_ff  <= image_cols_in;
         kernel_rows_ff <= kernel_rows_in;
         kernel_cols_ff <= kernel_cols_in;
         step_ff        <= step_in;
      end
   end

   // saturate into range, zero reads as one
   always_comb begin
      ch_c = (channels_ff == '0) ? CH_W'(1) :
             (channels_ff > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : channels_ff;
      ir_c = (image_rows_ff == '0) ? DIM_W'(1) :
             (image_rows_ff > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : image_rows_ff;
      ic_c = (image_cols_ff == '0) ? DIM_W'(1) :
             (image_cols_ff > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : image_cols_ff;
      kr_c = (kernel_rows_ff == '0) ? KER_W'(1) :
             (kernel_rows_ff > KER_W'(MAX_KERNEL_DIM)) ? KER_W'(MAX_KERNEL_DIM) :
             kernel_rows_ff;
      kc_c = (kernel_cols_ff == '0) ? KER_W'(1) :
             (kernel_cols_ff > KER_W'(MAX_KERNEL_DIM)) ? KER_W'(MAX_KERNEL_DIM) :
             kernel_cols_ff;
      st_c = (step_ff == '0) ? STEP_W'(1) :
             (step_ff > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : step_ff;
      recip_c   = step_recip(st_c);
      mr_full   = ir_c - {5'd0, kr_c};
      mc_full   = ic_c - {5'd0, kc_c};
      prow_prod = {12'd0, mr_full[7:0]} * {8'd0, recip_c};
      pcol_prod = {12'd0, mc_full[7:0]} * {8'd0, recip_c};
      ka_full   = {4'd0, kr_c} * {4'd0, kc_c};
      stkc_full = {4'd0, st_c} * {4'd0, kc_c};
      pcount_full = {9'd0, prow_ff} * {9'd0, pcol_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mr_ff      <= COORD_W'(MR_RST);
         mc_ff      <= COORD_W'(MR_RST);
         geom_ok_ff <= 1'b1;
         prow_ff    <= DIM_W'(PROW_RST);
         pcol_ff    <= DIM_W'(PROW_RST);
         ka_ff      <= AREA_W'(9);
         stkc_ff    <= AREA_W'(3);
         recip_ff   <= step_recip(STEP_RST);
         pcount_ff  <= PCNT_W'(PCOUNT_RST);
      end else begin
         mr_ff      <= mr_full[7:0];
         mc_ff      <= mc_full[7:0];
         geom_ok_ff <= ({5'd0, kr_c} <= ir_c) && ({5'd0, kc_c} <= ic_c);
         prow_ff    <= {1'b0, prow_prod[18:11]} + DIM_W'(1);
         pcol_ff    <= {1'b0, pcol_prod[18:11]} + DIM_W'(1);
         ka_ff      <= ka_full[AREA_W-1:0];
         stkc_ff    <= stkc_full[AREA_W-1:0];
         recip_ff   <= recip_c;
         pcount_ff  <= pcount_full[PCNT_W-1:0];
      end
   end

   assign cfg.ch      = ch_c;
   assign cfg.ir      = ir_c;
   assign cfg.ic      = ic_c;
   assign cfg.kr      = kr_c;
   assign cfg.kc      = kc_c;
   assign cfg.st      = st_c;
   assign cfg.recip   = recip_ff;
   assign cfg.mr      = mr_ff;
   assign cfg.mc      = mc_ff;
   assign cfg.geom_ok = geom_ok_ff;
   assign cfg.pcol    = pcol_ff;
   assign cfg.pcount  = pcount_ff;
   assign cfg.ka      = ka_ff;
   assign cfg.stkc    = stkc_ff;

endmodule

>>> hdl/im2col_front.sv
// ----------------------------------------------------------------------------
// im2col front end
// Accepts samples, finds the span of covering patches and queues a command.
// ----------------------------------------------------------------------------
module im2col_front import im2col_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   input  cfg_type           cfg,
   input  logic [QCNT_W-1:0] q_count,
   output logic              q_push,
   output cmd_type           q_cmd
);

   typedef struct packed {
      logic                     ok;
      logic [COORD_W-1:0]       prh;
      logic [COORD_W-1:0]       prl;
      logic [COORD_W-1:0]       pch;
      logic [COORD_W-1:0]       pcl;
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic [COORD_W-1:0]       b;
      logic [COL_W-1:0]         col_c;
      logic signed [WORD_W-1:0] sample;
   } s2_type;

   typedef struct packed {
      logic                     keep;
      logic [ROW_W-1:0]         bp;
      logic [PCNT_W-1:0]        rp;
      logic [COORD_W-1:0]       pch;
      logic [COL_W-1:0]         col_c;
      logic [KOFF_W-1:0]        kx;
      logic [KOFF_W-1:0]        ky;
      logic [KOFF_W-1:0]        nr;
      logic [KOFF_W-1:0]        nc;
      logic signed [WORD_W-1:0] sample;
   } s3_type;

   logic    v1_ff, v2_ff, v3_ff;
   req_type s1_ff;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;

   logic [QCNT_W:0] used;
   logic            accept;

   // span of one dimension: top patch limit and ceil numerator of the bottom
   function automatic logic [16:0] dim_span(input logic [COORD_W-1:0] p,
                                            input logic [COORD_W-1:0] m,
                                            input logic [KER_W-1:0]   k,
                                            input logic [STEP_W-1:0]  st);
      logic [COORD_W-1:0] hi;
      logic [8:0]         p1;
      logic [8:0]         lo;
      p1 = {1'b0, p} + 9'd1;
      hi = (p < m) ? p : m;
      lo = (p1 >= {5'd0, k}) ? (p1 - {5'd0, k}) : 9'd0;
      return {hi, lo + {5'd0, st} - 9'd1};
   endfunction

   logic [16:0] span_r, span_c;
   logic [19:0] prh_prod, prl_prod, pch_prod, pcl_prod;
   logic [12:0] col_prod;
   logic [11:0] rst_prod, cst_prod;
   logic [COORD_W-1:0] nr_full, nc_full, kx_full, ky_full;
   logic [24:0] bp_prod;
   logic [16:0] rp_prod;
   logic [6:0]  kxkc;

   // credit covers every item between the accept and the queue
   assign used   = {{QCNT_W{1'b0}}, v1_ff} + {{QCNT_W{1'b0}}, v2_ff}
                 + {{QCNT_W{1'b0}}, v3_ff} + {1'b0, q_count};
   assign busy   = used >= (QCNT_W+1)'(Q_DEPTH);
   assign accept = start && !busy;

   // stage 1: range check and patch bounds by reciprocal
   always_comb begin
      span_r   = dim_span(s1_ff.pixel_row, cfg.mr, cfg.kr, cfg.st);
      span_c   = dim_span(s1_ff.pixel_col, cfg.mc, cfg.kc, cfg.st);
      prh_prod = {12'd0, span_r[16:9]} * {8'd0, cfg.recip};
      prl_prod = {11'd0, span_r[8:0]} * {8'd0, cfg.recip};
      pch_prod = {12'd0, span_c[16:9]} * {8'd0, cfg.recip};
      pcl_prod = {11'd0, span_c[8:0]} * {8'd0, cfg.recip};
      col_prod = {7'd0, s1_ff.channel_index} * {6'd0, cfg.ka};
      // batch index is eight bits wide, so it is always below MAX_BATCH
      s2_in.ok     = ({1'b0, s1_ff.pixel_row} < cfg.ir) && ({1'b0, s1_ff.pixel_col} < cfg.ic)
                   && ({1'b0, s1_ff.channel_index} < cfg.ch) && cfg.geom_ok;
      s2_in.prh    = prh_prod[18:RECIP_SH];
      s2_in.prl    = prl_prod[18:RECIP_SH];
      s2_in.pch    = pch_prod[18:RECIP_SH];
      s2_in.pcl    = pcl_prod[18:RECIP_SH];
      s2_in.x      = s1_ff.pixel_row;
      s2_in.y      = s1_ff.pixel_col;
      s2_in.b      = s1_ff.batch_index;
      s2_in.col_c  = col_prod[COL_W-1:0];
      s2_in.sample = s1_ff.sample;
   end

   // stage 2: first kernel offset, span counts and row products
   always_comb begin
      rst_prod = {4'd0, s2_ff.prh} * {8'd0, cfg.st};
      cst_prod = {4'd0, s2_ff.pch} * {8'd0, cfg.st};
      kx_full  = s2_ff.x - rst_prod[COORD_W-1:0];
      ky_full  = s2_ff.y - cst_prod[COORD_W-1:0];
      nr_full  = s2_ff.prh - s2_ff.prl;
      nc_full  = s2_ff.pch - s2_ff.pcl;
      bp_prod  = {17'd0, s2_ff.b} * {8'd0, cfg.pcount};
      rp_prod  = {9'd0, s2_ff.prh} * {8'd0, cfg.pcol};
      s3_in.keep   = s2_ff.ok && (s2_ff.prl <= s2_ff.prh) && (s2_ff.pcl <= s2_ff.pch);
      s3_in.bp     = bp_prod[ROW_W-1:0];
      s3_in.rp     = rp_prod;
      s3_in.pch    = s2_ff.pch;
      s3_in.col_c  = s2_ff.col_c;
      s3_in.kx     = kx_full[KOFF_W-1:0];
      s3_in.ky     = ky_full[KOFF_W-1:0];
      s3_in.nr     = nr_full[KOFF_W-1:0];
      s3_in.nc     = nc_full[KOFF_W-1:0];
      s3_in.sample = s2_ff.sample;
   end

   // stage 3: first placement, then push
   always_comb begin
      kxkc         = {4'd0, s3_ff.kx} * {3'd0, cfg.kc};
      q_cmd.row    = s3_ff.bp + {7'd0, s3_ff.rp} + {16'd0, s3_ff.pch};
      q_cmd.col    = s3_ff.col_c + {5'd0, kxkc} + {9'd0, s3_ff.ky};
      q_cmd.sample = s3_ff.sample;
      q_cmd.nr     = s3_ff.nr;
      q_cmd.nc     = s3_ff.nc;
      q_push       = v3_ff && s3_ff.keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= req_data;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

>>> hdl/im2col_queue.sv
// ----------------------------------------------------------------------------
// im2col command queue
// Short first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
module im2col_queue import im2col_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  cmd_type           q_cmd,
   input  logic              q_pop,
   output cmd_type           q_head,
   output logic              q_empty,
   output logic [QCNT_W-1:0] q_count
);

   cmd_type           mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !q_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_cmd;
      end
   end

   assign q_head  = mem_ff[rd_ptr_ff];
   assign q_empty = (count_ff == '0);
   assign q_count = count_ff;

endmodule

>>> hdl/im2col_back.sv
// ----------------------------------------------------------------------------
// im2col back end
// Walks the covering patches of one command, one placement per cycle.
// ----------------------------------------------------------------------------
module im2col_back import im2col_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type q_head,
   input  logic    q_empty,
   output logic    q_pop,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic                     active_ff, active_in;
   logic [KOFF_W-1:0]        ri_ff, ri_in, ci_ff, ci_in;
   logic [KOFF_W-1:0]        nr_ff, nr_in, nc_ff, nc_in;
   logic [ROW_W-1:0]         row_cur_ff, row_cur_in, row_line_ff, row_line_in;
   logic [COL_W-1:0]         col_cur_ff, col_cur_in, col_line_ff, col_line_in;
   logic signed [WORD_W-1:0] sample_ff, sample_in;
   logic                     is_last, take;

   always_comb begin
      is_last     = active_ff && (ri_ff == nr_ff) && (ci_ff == nc_ff);
      take        = !active_ff || is_last;
      q_pop       = take && !q_empty;
      active_in   = active_ff;
      ri_in       = ri_ff;
      ci_in       = ci_ff;
      nr_in       = nr_ff;
      nc_in       = nc_ff;
      row_cur_in  = row_cur_ff;
      row_line_in = row_line_ff;
      col_cur_in  = col_cur_ff;
      col_line_in = col_line_ff;
      sample_in   = sample_ff;
      if (take) begin
         // load the next command straight after the last beat
         active_in   = !q_empty;
         ri_in       = '0;
         ci_in       = '0;
         nr_in       = q_head.nr;
         nc_in       = q_head.nc;
         row_cur_in  = q_head.row;
         row_line_in = q_head.row;
         col_cur_in  = q_head.col;
         col_line_in = q_head.col;
         sample_in   = q_head.sample;
      end else if (ci_ff != nc_ff) begin
         ci_in      = ci_ff + KOFF_W'(1);
         row_cur_in = row_cur_ff - ROW_W'(1);
         col_cur_in = col_cur_ff + {8'd0, cfg.st};
      end else begin
         ci_in       = '0;
         ri_in       = ri_ff + KOFF_W'(1);
         row_line_in = row_line_ff - {15'd0, cfg.pcol};
         row_cur_in  = row_line_ff - {15'd0, cfg.pcol};
         col_line_in = col_line_ff + {5'd0, cfg.stkc};
         col_cur_in  = col_line_ff + {5'd0, cfg.stkc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      ri_ff       <= ri_in;
      ci_ff       <= ci_in;
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      row_cur_ff  <= row_cur_in;
      row_line_ff <= row_line_in;
      col_cur_ff  <= col_cur_in;
      col_line_ff <= col_line_in;
      sample_ff   <= sample_in;
   end

   assign rsp_valid           = active_ff;
   assign rsp_data.matrix_row = row_cur_ff;
   assign rsp_data.matrix_col = col_cur_ff;
   assign rsp_data.sample_res = sample_ff;
   assign rsp_data.last       = is_last;

endmodule

>>> hdl/im2col_patch_scatter_unit.sv
// ----------------------------------------------------------------------------
// im2col patch scatter unit
// Path: each accepted sample passes the front stages and the queue before the back end emits its first placement.
// Throughput: one placement per cycle from the back end walk; a sample gets one
// beat per placement (up to nine for a 3x3 kernel at stride 1), none if it has
// no placement. Up to eight samples sit between accept and walk.
// The receiver cannot stall. Reset is synchronous: registers return to their
// reset values and every sample in flight is dropped.
// ----------------------------------------------------------------------------
module im2col_patch_scatter_unit import im2col_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // placement channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg;
   cmd_type           q_cmd, q_head;
   logic              q_push, q_pop, q_empty;
   logic [QCNT_W-1:0] q_count;

   // Registers, clamped, with patch counts and kernel area kept in flops.
   im2col_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Front: three stages. Check the sample against the image, find the
   // covering patch rows and columns by reciprocal of the step, then form
   // the first placement. Drop samples with no placement; queue the rest.
   // Busy counts the samples in these stages plus the queue fill, so a push
   // always finds room.
   im2col_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   // Queue: holds commands while the back end is still walking.
   im2col_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_count (q_count)
   );

   // Back: walk kernel offsets in raster order, one beat per cycle. Step the
   // matrix row down by one per column and by the patch column count per row;
   // advance the matrix column by the step. Load the next command on the last
   // beat so consecutive samples run with no gap.
   im2col_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_im2col_patch_scatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// im2col patch scatter unit - self-checking testbench
// Samples go in as command beats and placements come back as strobed beats.
// A local scatter predictor works out every placement of each model-checked sample.
// Each placement beat is checked field by field against the oldest one due.
// A directed table comes first. Random samples then follow under nine register
// geometries, with the sender idling at different rates.
// ----------------------------------------------------------------------------
module tb_im2col_patch_scatter_unit;
   import im2col_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no beat of any kind
   localparam int SETTLE_TAIL    = 64;     // covers samples that place nothing
   localparam int MAX_REPORTS    = 10;
   localparam int PER_GEOMETRY   = 48;     // samples sent per geometry
   localparam int NUM_GEOMETRIES = 9;
   localparam int NUM_DIRECTED   = 24;

   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [0:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_ONE} check_mode_t;

   typedef struct packed {
      row_kind_t               kind;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   wdata;
      req_type                 item;
      check_mode_t             mode;
      logic [ROW_W-1:0]        row;    // typed placement, CHECK_ONE only
      logic [COL_W-1:0]        col;
   } directed_row_t;

   // raw register values, written as they stand (out-of-range ones included)
   typedef struct packed {
      logic [CSR_DATA_W-1:0] ch;
      logic [CSR_DATA_W-1:0] ir;
      logic [CSR_DATA_W-1:0] ic;
      logic [CSR_DATA_W-1:0] kr;
      logic [CSR_DATA_W-1:0] kc;
      logic [CSR_DATA_W-1:0] st;
   } geometry_t;

   // Directed part, under the reset geometry (8x8 image, 3x3 kernel, step 1,
   // one channel) until the write rows change it.
   localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
      // top-left corner: only the first kernel offset of patch 0
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd0, 8'd0, 8'd0, 6'd0, 32'sh0000_0000},
        CHECK_ONE, 24'd0, 12'd0},
      // bottom-right corner: last offset of the last patch (5 * 6 + 5)
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd0, 8'd7, 8'd7, 6'd0, 32'sh7FFF_FFFF},
        CHECK_ONE, 24'd35, 12'd8},
      // top batch index: row is 255 times 36 patches
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd255, 8'd0, 8'd0, 6'd0, 32'sh8000_0000},
        CHECK_ONE, 24'd9180, 12'd0},
      // outside the image: row, column, channel, everything at once
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd0, 8'd8, 8'd0, 6'd0, 32'sh0000_0001},
        CHECK_NONE, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd0, 8'd0, 8'd8, 6'd0, 32'sh0000_0002},
        CHECK_NONE, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd0, 8'd0, 8'd0, 6'd1, 32'sh0000_0003},
        CHECK_NONE, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd255, 8'd255, 8'd255, 6'd63, 32'shFFFF_FFFF},
        CHECK_NONE, '0, '0},
      // centre sample: full 3x3 fan-out
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd3, 8'd4, 8'd4, 6'd0, 32'sh1234_5678},
        CHECK_MODEL, '0, '0},
      // writes to undecoded indexes must leave the geometry alone
      '{ROW_WRITE, CSR_SPARE_LO, 9'h1FF, '0, CHECK_MODEL, '0, '0},
      '{ROW_WRITE, CSR_SPARE_HI, 9'h000, '0, CHECK_MODEL, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd1, 8'd2, 8'd3, 6'd0, 32'sh5A5A_5A5A},
        CHECK_MODEL, '0, '0},
      // widest channel count, top channel
      '{ROW_WRITE, CSR_CHANNELS, 9'd64, '0, CHECK_MODEL, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd200, 8'd1, 8'd1, 6'd63, 32'shA5A5_A5A5},
        CHECK_MODEL, '0, '0},
      // zero kernel height reads as one
      '{ROW_WRITE, CSR_KERNEL_ROWS, 9'd0, '0, CHECK_MODEL, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd9, 8'd6, 8'd5, 6'd40, 32'shDEAD_BEEF},
        CHECK_MODEL, '0, '0},
      // kernel taller than the image: no patch at all
      '{ROW_WRITE, CSR_IMAGE_ROWS, 9'd4, '0, CHECK_MODEL, '0, '0},
      '{ROW_WRITE, CSR_KERNEL_ROWS, 9'd8, '0, CHECK_MODEL, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd7, 8'd2, 8'd2, 6'd0, 32'sh0BAD_F00D},
        CHECK_NONE, '0, '0},
      // 1x1 kernel at step 3: rows off the stride grid are never covered
      '{ROW_WRITE, CSR_IMAGE_ROWS, 9'd8, '0, CHECK_MODEL, '0, '0},
      '{ROW_WRITE, CSR_KERNEL_ROWS, 9'd1, '0, CHECK_MODEL, '0, '0},
      '{ROW_WRITE, CSR_KERNEL_COLS, 9'd1, '0, CHECK_MODEL, '0, '0},
      '{ROW_WRITE, CSR_STEP, 9'd3, '0, CHECK_MODEL, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd5, 8'd1, 8'd0, 6'd0, 32'sh0000_0077},
        CHECK_NONE, '0, '0},
      '{ROW_SAMPLE, CSR_CHANNELS, 9'd0, '{8'd5, 8'd3, 8'd6, 6'd2, 32'sh7777_0000},
        CHECK_MODEL, '0, '0}
   };

   // Geometries for the random part; the last slot is drawn at run time.
   localparam geometry_t GEOMETRIES [NUM_GEOMETRIES - 1] = '{
      '{9'd1,   9'd8,   9'd8,   9'd3,  9'd3,  9'd1},    // reset geometry
      '{9'd64,  9'd256, 9'd256, 9'd8,  9'd8,  9'd1},    // widest: 64 placements
      '{9'd3,   9'd12,  9'd9,   9'd2,  9'd4,  9'd2},
      '{9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0},    // all zero, reads as ones
      '{9'h1FF, 9'h1FF, 9'h1FF, 9'hF,  9'hF,  9'hF},    // all over range, saturates
      '{9'd5,   9'd20,  9'd17,  9'd5,  9'd3,  9'd3},
      '{9'd16,  9'd1,   9'd256, 9'd1,  9'd8,  9'd4},    // single image row
      '{9'd2,   9'd7,   9'd7,   9'd7,  9'd7,  9'd8}     // kernel fills the image
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CHANNELS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the register file, as the block stores it
   logic [CH_W-1:0]   reg_channels = CHANNELS_RST;
   logic [DIM_W-1:0]  reg_rows     = IMAGE_ROWS_RST;
   logic [DIM_W-1:0]  reg_cols     = IMAGE_COLS_RST;
   logic [KER_W-1:0]  reg_krows    = KERNEL_ROWS_RST;
   logic [KER_W-1:0]  reg_kcols    = KERNEL_COLS_RST;
   logic [STEP_W-1:0] reg_step     = STEP_RST;

   rsp_type     placements_due [$];
   rsp_type     due;
   int unsigned placements_owed   = 0;   // pushed by the sender
   int unsigned placements_seen   = 0;   // matched beats, updated at the edge
   int unsigned samples_sent      = 0;
   int unsigned samples_placing   = 0;
   int unsigned fault_count       = 0;
   int unsigned quiet_cycles      = 0;
   int unsigned sender_idle_pct   = 0;

   im2col_patch_scatter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Registers are used saturated into their range; zero reads as one.
   function automatic int unsigned sat(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Scatter predictor: queue every placement of one sample, in raster order of
   // kernel offset, and flag the final one. Returns the number queued.
   // The batch field is 8 bits wide, so it can never reach MAX_BATCH.
   function automatic int scatter_sample(input req_type s);
      int unsigned ch, ir, ic, kr, kc, st;
      int unsigned prow, pcol, pcount, top, left, pidx;
      int          n;
      rsp_type     p;
      ch = sat(reg_channels, MAX_CHANNELS);
      ir = sat(reg_rows, MAX_IMAGE_DIM);
      ic = sat(reg_cols, MAX_IMAGE_DIM);
      kr = sat(reg_krows, MAX_KERNEL_DIM);
      kc = sat(reg_kcols, MAX_KERNEL_DIM);
      st = sat(reg_step, MAX_STEP);
      n  = 0;
      if (s.pixel_row >= ir || s.pixel_col >= ic || s.channel_index >= ch) return 0;
      if (kr > ir || kc > ic) return 0;
      prow   = (ir - kr) / st + 1;
      pcol   = (ic - kc) / st + 1;
      pcount = prow * pcol;
      for (int unsigned kx = 0; kx < kr; kx++) begin
         for (int unsigned ky = 0; ky < kc; ky++) begin
            if (kx > s.pixel_row || ky > s.pixel_col) continue;
            top  = s.pixel_row - kx;
            left = s.pixel_col - ky;
            // patch must lie inside the image and start on the stride grid
            if (top > ir - kr || left > ic - kc) continue;
            if (top % st != 0 || left % st != 0) continue;
            pidx         = (top / st) * pcol + left / st;
            p.matrix_row = ROW_W'(s.batch_index * pcount + pidx);
            p.matrix_col = COL_W'(kx * kc + ky + s.channel_index * kr * kc);
            p.sample_res = s.sample;
            p.last       = 1'b0;
            placements_due.push_back(p);
            n++;
         end
      end
      if (n > 0) placements_due[placements_due.size() - 1].last = 1'b1;
      return n;
   endfunction

   // Draw a sample: mostly inside the configured image, otherwise any bits.
   function automatic req_type pick_sample(input bit noise);
      req_type s;
      s.batch_index = COORD_W'($urandom);
      s.sample      = $urandom;
      if (noise) begin
         s.pixel_row     = COORD_W'($urandom);
         s.pixel_col     = COORD_W'($urandom);
         s.channel_index = CHAN_W'($urandom);
      end else begin
         s.pixel_row     = COORD_W'($urandom_range(0, sat(reg_rows, MAX_IMAGE_DIM) - 1));
         s.pixel_col     = COORD_W'($urandom_range(0, sat(reg_cols, MAX_IMAGE_DIM) - 1));
         s.channel_index = CHAN_W'($urandom_range(0, sat(reg_channels, MAX_CHANNELS) - 1));
      end
      return s;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // Present one sample beat and hold it until the block takes it. Called just
   // after a rising edge; returns at the edge where the beat is accepted.
   task automatic drive_sample(input req_type s, input check_mode_t mode,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                               output int n);
      rsp_type p;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (busy);
      samples_sent++;
      case (mode)
         CHECK_MODEL: n = scatter_sample(s);
         CHECK_NONE:  n = 0;
         default: begin
            p.matrix_row = row;
            p.matrix_col = col;
            p.sample_res = s.sample;
            p.last       = 1'b1;
            placements_due.push_back(p);
            n = 1;
         end
      endcase
      placements_owed += n;
      if (n > 0) samples_placing++;
   endtask

   // Drop start and hold until every placement due has arrived, then let the
   // tail run out so that samples with no placement have left the block too.
   task automatic settle(input int tail);
      start <= 1'b0;
      do @(posedge clock); while (placements_seen != placements_owed);
      repeat (tail) @(posedge clock);
   endtask

   // One register write, then a cycle with the enable low.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_CHANNELS:    reg_channels = value[CH_W-1:0];
         CSR_IMAGE_ROWS:  reg_rows     = value[DIM_W-1:0];
         CSR_IMAGE_COLS:  reg_cols     = value[DIM_W-1:0];
         CSR_KERNEL_ROWS: reg_krows    = value[KER_W-1:0];
         CSR_KERNEL_COLS: reg_kcols    = value[KER_W-1:0];
         CSR_STEP:        reg_step     = value[STEP_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_geometry(input geometry_t g);
      write_reg(CSR_CHANNELS, g.ch);
      write_reg(CSR_IMAGE_ROWS, g.ir);
      write_reg(CSR_IMAGE_COLS, g.ic);
      write_reg(CSR_KERNEL_ROWS, g.kr);
      write_reg(CSR_KERNEL_COLS, g.kc);
      write_reg(CSR_STEP, g.st);
   endtask

   // Placement check and watchdog. Every beat the block sends is taken at the
   // edge that ends its cycle; compare it with the oldest placement due.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_valid || csr_we) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid) begin
            if (placements_due.size() == 0) begin
               note_fault($sformatf("unexpected placement row %0d col %0d sample %h last %b",
                                    rsp_data.matrix_row, rsp_data.matrix_col,
                                    rsp_data.sample_res, rsp_data.last));
            end else begin
               due = placements_due.pop_front();
               if (rsp_data.matrix_row !== due.matrix_row ||
                   rsp_data.matrix_col !== due.matrix_col ||
                   rsp_data.sample_res !== due.sample_res ||
                   rsp_data.last !== due.last) begin
                  note_fault($sformatf({"placement %0d: expected row %0d col %0d sample %h",
                                        " last %b, got row %0d col %0d sample %h last %b"},
                                       placements_seen, due.matrix_row, due.matrix_col,
                                       due.sample_res, due.last, rsp_data.matrix_row,
                                       rsp_data.matrix_col, rsp_data.sample_res,
                                       rsp_data.last));
               end
               placements_seen <= placements_seen + 1;
            end
         end
      end
   end

   // Watchdog: the run ends if no beat of any kind moves for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("Timeout: no beat for %0d cycles, %0d placements still due",
               WATCHDOG_LIMIT, placements_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      directed_row_t row;
      geometry_t     g;
      int            n;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table; settle before each write so the block is idle.
      sender_idle_pct = 0;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_WRITE) begin
            settle(SETTLE_TAIL);
            write_reg(row.index, row.wdata);
         end else begin
            drive_sample(row.item, row.mode, row.row, row.col, n);
         end
      end

      // Random part: sender idles at 14 %, then 54 %, then not at all.
      for (int gi = 0; gi < NUM_GEOMETRIES; gi++) begin
         settle(SETTLE_TAIL);
         if (gi < NUM_GEOMETRIES - 1) begin
            g = GEOMETRIES[gi];
         end else begin
            g.ch = CSR_DATA_W'($urandom_range(1, 64));
            g.ir = CSR_DATA_W'($urandom_range(1, 64));
            g.ic = CSR_DATA_W'($urandom_range(1, 64));
            g.kr = CSR_DATA_W'($urandom_range(1, (g.ir < 8) ? g.ir : 8));
            g.kc = CSR_DATA_W'($urandom_range(1, (g.ic < 8) ? g.ic : 8));
            g.st = CSR_DATA_W'($urandom_range(1, 8));
         end
         apply_geometry(g);
         sender_idle_pct = (gi < 3) ? 14 : (gi < 6) ? 54 : 0;
         for (int k = 0; k < PER_GEOMETRY; k++) begin
            drive_sample(pick_sample($urandom_range(0, 99) < 15), CHECK_MODEL, '0, '0, n);
            // now and then hold off until the block has drained
            if ($urandom_range(0, 59) == 0) settle(0);
         end
      end

      settle(SETTLE_TAIL);
      $display("Sent %0d samples (%0d with placements) over the directed table and %0d geometries",
               samples_sent, samples_placing, NUM_GEOMETRIES);
      $display("Checked %0d placements, %0d faults", placements_seen, fault_count);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
